FILE: src/dbsg_pkg.sv
package dbsg_pkg;

  localparam int unsigned MAX_ORDER_DEF   = 8;
  localparam int unsigned SYMBOL_BITS_DEF = 4;

  localparam int unsigned ALPHA_W    = 5;
  localparam int unsigned ORDER_W    = 4;
  localparam int unsigned CFG_DATA_W = 5;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORDER    = 1'b1;

  localparam logic [ALPHA_W-1:0] ALPHA_RST = 5'd10;
  localparam logic [ORDER_W-1:0] ORDER_RST = 4'd2;

  typedef struct packed {
    logic clear;
    logic load_out;
    logic idx_inc;
    logic idx_one;
    logic step;
    logic copy;
  } dbsg_cmd_t;

  typedef struct packed {
    logic idx_lt_p;
    logic srch_zero;
    logic copy_done;
    logic divides;
  } dbsg_sts_t;

endpackage

FILE: src/de_bruijn_sequence_generator.sv
// De Bruijn sequence generator B(k,n), one symbol per transfer.
// Input channel (in_valid_i / in_stall_o, payload restart_i): each transfer
// requests one symbol; restart_i = 1 restarts the sequence and returns its
// first symbol. Output channel (out_valid_o / out_stall_i): symbol_o and
// cycle_end_o, which marks the last symbol of each k^n cycle.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i
// (0 = alphabet size k, 1 = word order n); every write restarts the sequence.
// Write only while no request is in flight.
// A request passes the search state, then the emit state, which loads the
// symbol into the output register once the output slot is free. The last
// symbol of a word also runs the successor step: raise the rightmost digit
// below k-1, then copy the period, repeated while the new period j does not
// divide n. The copy runs one digit per cycle through the single read port
// of the digit register file.
// Reset: k = 10, n = 2, sequence at its first symbol, output empty.
// A stalled output holds its symbol; one further request is taken and held
// until the output register frees up.
module de_bruijn_sequence_generator import dbsg_pkg::*; #(
  parameter int unsigned MAX_ORDER   = MAX_ORDER_DEF,
  parameter int unsigned SYMBOL_BITS = SYMBOL_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   restart_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [SYMBOL_BITS-1:0] symbol_o,
  output logic                   cycle_end_o
);

  dbsg_cmd_t cmd;
  dbsg_sts_t sts;

  dbsg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .restart_i   (restart_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dbsg_datapath #(
    .MAX_ORDER   (MAX_ORDER),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .symbol_o    (symbol_o),
    .cycle_end_o (cycle_end_o)
  );

endmodule

FILE: src/dbsg_datapath.sv
module dbsg_datapath import dbsg_pkg::*; #(
  parameter int unsigned MAX_ORDER   = MAX_ORDER_DEF,
  parameter int unsigned SYMBOL_BITS = SYMBOL_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  dbsg_cmd_t              cmd_i,
  output dbsg_sts_t              sts_o,
  output logic [SYMBOL_BITS-1:0] symbol_o,
  output logic                   cycle_end_o
);

  localparam int unsigned CNT_W = $clog2(MAX_ORDER + 2);
  localparam logic [8:0]  KMAX  = 9'(1 << SYMBOL_BITS);
  localparam logic [4:0]  NMAX  = 5'(MAX_ORDER);

  logic [ALPHA_W-1:0]     alph_q;
  logic [ORDER_W-1:0]     order_q;
  logic                   cfg_hit;
  logic                   clear;

  logic [SYMBOL_BITS-1:0] digits_q [MAX_ORDER];
  logic [CNT_W-1:0]       p_q, idx_q, i_q, r_q, srch_q, srch_d;
  logic [SYMBOL_BITS-1:0] sym_q;
  logic                   end_q;

  logic [8:0]             a9, top9;
  logic [4:0]             o5, n5;
  logic [SYMBOL_BITS-1:0] sym_top;
  logic [CNT_W-1:0]       n_eff;
  logic [CNT_W-1:0]       rd_pos;
  logic [SYMBOL_BITS-1:0] rd_data;

  always_comb begin
    cfg_hit = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ALPHABET: cfg_hit = 1'b1;
        CFG_ORDER:    cfg_hit = 1'b1;
        default:      cfg_hit = 1'b0;
      endcase
    end
  end

  assign clear = cmd_i.clear || cfg_hit;

  always_comb begin
    a9 = 9'(alph_q);
    priority if (a9 < 9'd2) begin
      top9 = 9'd1;
    end else if (a9 > KMAX) begin
      top9 = KMAX - 9'd1;
    end else begin
      top9 = a9 - 9'd1;
    end
    sym_top = top9[SYMBOL_BITS-1:0];

    o5 = 5'(order_q);
    priority if (o5 < 5'd1) begin
      n5 = 5'd1;
    end else if (o5 > NMAX) begin
      n5 = NMAX;
    end else begin
      n5 = o5;
    end
    n_eff = CNT_W'(n5);
  end

  // rightmost position within the word whose digit can still be raised
  always_comb begin
    srch_d = '0;
    for (int e = 0; e < MAX_ORDER; e++) begin
      if ((digits_q[e] < sym_top) && (CNT_W'(e + 1) <= n_eff)) begin
        srch_d = CNT_W'(e + 1);
      end
    end
  end

  assign rd_pos = cmd_i.copy ? (i_q - p_q) : idx_q;

  always_comb begin
    rd_data = '0;
    for (int e = 0; e < MAX_ORDER; e++) begin
      if (rd_pos == CNT_W'(e + 1)) begin
        rd_data = digits_q[e];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alph_q  <= ALPHA_RST;
      order_q <= ORDER_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ALPHABET: alph_q  <= cfg_data_i[ALPHA_W-1:0];
        CFG_ORDER:    order_q <= cfg_data_i[ORDER_W-1:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int e = 0; e < MAX_ORDER; e++) begin
        digits_q[e] <= '0;
      end
      p_q    <= CNT_W'(1);
      idx_q  <= CNT_W'(1);
      srch_q <= '0;
    end else begin
      srch_q <= srch_d;
      if (clear) begin
        for (int e = 0; e < MAX_ORDER; e++) begin
          digits_q[e] <= '0;
        end
        p_q   <= CNT_W'(1);
        idx_q <= CNT_W'(1);
      end else begin
        if (cmd_i.step) begin
          for (int e = 0; e < MAX_ORDER; e++) begin
            if (srch_q == CNT_W'(e + 1)) begin
              digits_q[e] <= digits_q[e] + SYMBOL_BITS'(1);
            end
          end
          p_q <= srch_q;
        end
        if (cmd_i.copy) begin
          for (int e = 0; e < MAX_ORDER; e++) begin
            if (i_q == CNT_W'(e + 1)) begin
              digits_q[e] <= rd_data;
            end
          end
        end
        if (cmd_i.idx_inc) begin
          idx_q <= idx_q + CNT_W'(1);
        end
        if (cmd_i.idx_one) begin
          idx_q <= CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      i_q <= srch_q + CNT_W'(1);
      r_q <= '0;
    end else if (cmd_i.copy) begin
      i_q <= i_q + CNT_W'(1);
      r_q <= (r_q == p_q - CNT_W'(1)) ? '0 : r_q + CNT_W'(1);
    end
    if (cmd_i.load_out) begin
      sym_q <= rd_data;
      end_q <= (idx_q == p_q) && (srch_q == '0);
    end
  end

  assign sts_o.idx_lt_p  = idx_q < p_q;
  assign sts_o.srch_zero = srch_q == '0;
  assign sts_o.copy_done = i_q > n_eff;
  assign sts_o.divides   = r_q == '0;

  assign symbol_o    = sym_q;
  assign cycle_end_o = end_q;

endmodule

FILE: src/dbsg_ctrl.sv
module dbsg_ctrl import dbsg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  logic      restart_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  dbsg_sts_t sts_i,
  output dbsg_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH,
    ST_EMIT,
    ST_NEXT,
    ST_COPY
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   slot_free;
  logic   accept;

  assign in_stall_o = state_q != ST_IDLE;
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign slot_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.clear = restart_i;
          state_d     = ST_SRCH;
        end
      end
      ST_SRCH: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          if (sts_i.idx_lt_p) begin
            cmd_o.idx_inc = 1'b1;
            state_d       = ST_IDLE;
          end else begin
            state_d = ST_NEXT;
          end
        end
      end
      ST_NEXT: begin
        if (sts_i.srch_zero) begin
          cmd_o.clear = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          cmd_o.step = 1'b1;
          state_d    = ST_COPY;
        end
      end
      ST_COPY: begin
        if (sts_i.copy_done) begin
          if (sts_i.divides) begin
            cmd_o.idx_one = 1'b1;
            state_d       = ST_IDLE;
          end else begin
            state_d = ST_NEXT;
          end
        end else begin
          cmd_o.copy = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: src/dbsg_checker.sv
module dbsg_checker import dbsg_pkg::*; #(
  parameter int unsigned SYMBOL_BITS = SYMBOL_BITS_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [SYMBOL_BITS-1:0] symbol_o,
  input logic                   cycle_end_o
);

  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(symbol_o) && $stable(cycle_end_o))
    else $error("stalled output changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while previous one in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("symbol appeared too early after request");

endmodule

bind de_bruijn_sequence_generator dbsg_checker #(
  .SYMBOL_BITS (SYMBOL_BITS)
) u_dbsg_checker (.*);

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import dbsg_pkg::*;

  localparam int unsigned MAX_ORD       = MAX_ORDER_DEF;
  localparam int unsigned SYM_W         = SYMBOL_BITS_DEF;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam int unsigned RANDOM_ITEMS  = 390;

  typedef struct {
    logic [SYM_W-1:0] symbol;
    logic             cycle_end;
  } symbol_t;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = CFG_ALPHABET;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic                  restart_i  = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [SYM_W-1:0]      symbol_o;
  logic                  cycle_end_o;

  logic [ALPHA_W-1:0] alpha_reg;
  logic [ORDER_W-1:0] order_reg;
  logic [SYM_W-1:0]   word_dig [0:MAX_ORD];
  logic [3:0]         word_period;
  logic [3:0]         emit_pos;
  symbol_t            symbol_q [$];

  int unsigned error_count = 0;
  int unsigned hold_cycles = 0;
  int unsigned cycle_count = 0;
  bit          quiet_src   = 1'b0;
  bit          quiet_snk   = 1'b0;

  de_bruijn_sequence_generator uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .restart_i   (restart_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .symbol_o    (symbol_o),
    .cycle_end_o (cycle_end_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int unsigned alphabet_k();
    if (alpha_reg < 2) return 2;
    if (alpha_reg > (1 << SYM_W)) return 1 << SYM_W;
    return alpha_reg;
  endfunction

  function automatic int unsigned order_n();
    if (order_reg < 1) return 1;
    if (order_reg > MAX_ORD) return MAX_ORD;
    return order_reg;
  endfunction

  function automatic void clear_sequence();
    foreach (word_dig[i]) word_dig[i] = '0;
    word_period = 4'd1;
    emit_pos    = 4'd1;
  endfunction

  function automatic int unsigned rightmost_raisable(int unsigned k, int unsigned n);
    for (int unsigned j = n; j >= 1; j--)
      if (word_dig[j] < k - 1) return j;
    return 0;
  endfunction

  function automatic void next_lyndon_word(int unsigned k, int unsigned n);
    int unsigned j;
    do begin
      j = rightmost_raisable(k, n);
      if (j == 0) begin
        clear_sequence();
        return;
      end
      word_dig[j] = word_dig[j] + 1'b1;
      for (int unsigned i = j + 1; i <= n; i++) word_dig[i] = word_dig[i - j];
      word_period = 4'(j);
    end while (n % j != 0);
    emit_pos = 4'd1;
  endfunction

  function automatic void predict_symbol(logic restart);
    int unsigned k, n, p, idx;
    symbol_t s;
    k = alphabet_k();
    n = order_n();
    if (restart) clear_sequence();
    p = word_period;
    if (p < 1 || p > n) p = 1;
    idx = emit_pos;
    if (idx < 1 || idx > p) idx = 1;
    s.symbol    = word_dig[idx];
    s.cycle_end = (idx == p) && (rightmost_raisable(k, n) == 0);
    symbol_q = {symbol_q, s};
    word_period = 4'(p);
    if (idx < p) emit_pos = 4'(idx + 1);
    else next_lyndon_word(k, n);
  endfunction

  task automatic send_request(logic restart);
    int unsigned gap;
    gap = quiet_src ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i  <= restart;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    predict_symbol(restart);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (symbol_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_ALPHABET) alpha_reg = data[ALPHA_W-1:0];
    else if (idx == CFG_ORDER) order_reg = data[ORDER_W-1:0];
    clear_sequence();
  endtask

  task automatic test_reset_state();
    repeat (4) send_request(1'b0);
  endtask

  task automatic test_restart();
    send_request(1'b1);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b1);
  endtask

  task automatic test_alphabet_limits();
    write_reg(CFG_ORDER, 5'd1);
    write_reg(CFG_ALPHABET, 5'd0);
    repeat (3) send_request(1'b0);
    write_reg(CFG_ALPHABET, 5'd31);
    repeat (2) send_request(1'b0);
  endtask

  task automatic test_order_limits();
    write_reg(CFG_ORDER, 5'd0);
    repeat (2) send_request(1'b0);
    write_reg(CFG_ALPHABET, 5'd2);
    write_reg(CFG_ORDER, 5'h1F);
    repeat (4) send_request(1'b0);
  endtask

  task automatic test_config_rewrite();
    write_reg(CFG_ORDER, 5'd1);
    send_request(1'b0);
    write_reg(CFG_ORDER, 5'd1);
    repeat (3) send_request(1'b0);
  endtask

  task automatic test_backpressure();
    write_reg(CFG_ALPHABET, 5'd3);
    write_reg(CFG_ORDER, 5'd3);
    quiet_src   = 1'b1;
    hold_cycles = 300;
    repeat (12) send_request(1'b0);
    quiet_src = 1'b0;
    wait_drained();
    repeat (20) send_request(1'b0);
  endtask

  task automatic test_random_sequences();
    int unsigned sent, len, k, n, burst, pick;
    logic [ALPHA_W-1:0] alpha;
    logic [ORDER_W-1:0] order;
    sent = 0;
    do begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        alpha = ALPHA_W'($urandom_range(0, 5));
        k     = (alpha < 2) ? 2 : alpha;
        order = (k == 2) ? ORDER_W'($urandom_range(0, 5))
                         : ORDER_W'($urandom_range(0, (k == 3) ? 3 : 2));
      end else if (pick == 6) begin
        alpha = ALPHA_W'($urandom_range(16, 31));
        order = ORDER_W'($urandom_range(0, 1));
      end else begin
        alpha = ALPHA_W'($urandom_range(0, 31));
        order = ORDER_W'($urandom_range(0, 15));
      end
      if ($urandom_range(0, 1) == 1) begin
        write_reg(CFG_ALPHABET, alpha);
        write_reg(CFG_ORDER, {$urandom_range(0, 1) == 1, order});
      end else begin
        write_reg(CFG_ORDER, {$urandom_range(0, 1) == 1, order});
        write_reg(CFG_ALPHABET, alpha);
      end
      k   = alphabet_k();
      n   = order_n();
      len = 1;
      for (int unsigned i = 0; i < n && len <= 1000; i++) len = len * k;
      burst = (len <= 40) ? 2 * len + $urandom_range(0, 4) : $urandom_range(10, 40);
      quiet_src = ($urandom_range(0, 3) == 0);
      quiet_snk = ($urandom_range(0, 3) == 0);
      for (int unsigned i = 0; i < burst; i++) begin
        if (i == burst / 2 && $urandom_range(0, 3) == 0) wait_drained();
        send_request($urandom_range(0, 29) == 0);
      end
      sent += burst;
    end while (sent < RANDOM_ITEMS);
    quiet_src = 1'b0;
    quiet_snk = 1'b0;
  endtask

  // Hold the receiver off for a counted stretch.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_cycles != 0) hold_cycles--;
    end
  end

  initial begin
    int unsigned gap;
    gap = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) gap = quiet_snk ? 0 : $urandom_range(0, 19);
      else if (gap != 0) gap--;
      out_stall_i <= (hold_cycles != 0) || (gap != 0);
    end
  end

  always @(posedge clk_i) begin
    symbol_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (symbol_q.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected transfer: symbol %0d cycle_end %0b", symbol_o, cycle_end_o);
      end else begin
        want = symbol_q.pop_front();
        if (want.symbol !== symbol_o || want.cycle_end !== cycle_end_o) begin
          error_count++;
          if (error_count <= 10)
            $display("symbol exp %0d got %0d, cycle_end exp %0b got %0b",
                     want.symbol, symbol_o, want.cycle_end, cycle_end_o);
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("de_bruijn_sequence_generator: mismatch");
    $finish;
  end

  initial begin
    alpha_reg = ALPHA_RST;
    order_reg = ORDER_RST;
    clear_sequence();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_restart();
    test_alphabet_limits();
    test_order_limits();
    test_config_rewrite();
    test_backpressure();
    test_random_sequences();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0 && symbol_q.size() == 0) begin
      $display("de_bruijn_sequence_generator: match");
    end else begin
      $display("de_bruijn_sequence_generator: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/dbsg_pkg.sv
src/dbsg_datapath.sv
src/dbsg_ctrl.sv
src/de_bruijn_sequence_generator.sv
src/dbsg_checker.sv
tb/tb_top.sv
